[sv/fsip_pkg.sv]
// Shared types, character codes and control store for the format string printer.
// Used by format_string_integer_printer; depends on nothing else.

package fsip_pkg;

  localparam int WIDTH_LIMIT_DEF = 63;
  localparam int BUF_DEPTH = 11;
  localparam int POS_W = $clog2(BUF_DEPTH + 1);
  localparam int PC_W = 4;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] DIV10_MAGIC = 32'hcccccccd;

  typedef enum logic [1:0] {
    PH_LITERAL,
    PH_PERCENT,
    PH_WIDTH
  } phase_e;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_DECODE,
    OP_EMIT_CH,
    OP_REN_INIT,
    OP_REN_DIG,
    OP_REN_SIGN,
    OP_PREP,
    OP_EMIT_SIGN,
    OP_EMIT_PAD,
    OP_EMIT_DIG,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_GOTO,
    C_DISPATCH,
    C_IF
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  localparam pc_t S_FETCH = 4'd0;
  localparam pc_t S_DECODE = 4'd1;
  localparam pc_t S_EMIT_CH = 4'd2;
  localparam pc_t S_REN_INIT = 4'd3;
  localparam pc_t S_REN_DIG = 4'd4;
  localparam pc_t S_REN_SIGN = 4'd5;
  localparam pc_t S_PREP = 4'd6;
  localparam pc_t S_EMIT_SIGN = 4'd7;
  localparam pc_t S_EMIT_PAD = 4'd8;
  localparam pc_t S_EMIT_DIG = 4'd9;
  localparam pc_t S_DONE = 4'd10;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_FETCH:     w = '{OP_FETCH,     C_NEXT,     S_FETCH};
      S_DECODE:    w = '{OP_DECODE,    C_DISPATCH, S_FETCH};
      S_EMIT_CH:   w = '{OP_EMIT_CH,   C_GOTO,     S_FETCH};
      S_REN_INIT:  w = '{OP_REN_INIT,  C_IF,       S_PREP};
      S_REN_DIG:   w = '{OP_REN_DIG,   C_IF,       S_REN_DIG};
      S_REN_SIGN:  w = '{OP_REN_SIGN,  C_NEXT,     S_FETCH};
      S_PREP:      w = '{OP_PREP,      C_IF,       S_DONE};
      S_EMIT_SIGN: w = '{OP_EMIT_SIGN, C_NEXT,     S_FETCH};
      S_EMIT_PAD:  w = '{OP_EMIT_PAD,  C_IF,       S_EMIT_PAD};
      S_EMIT_DIG:  w = '{OP_EMIT_DIG,  C_IF,       S_EMIT_DIG};
      S_DONE:      w = '{OP_CLEAR,     C_GOTO,     S_FETCH};
      default:     w = '{OP_CLEAR,     C_GOTO,     S_FETCH};
    endcase
    return w;
  endfunction

endpackage

[sv/format_string_integer_printer.sv]
// Format string printer for integers: a microcoded sequencer over a digit buffer.
// Depends on fsip_pkg for character codes, step numbers and the control store.
//
// Usage: present one format byte and a 32-bit value per request on the input
// channel (in_valid_i / in_stall_o). Literal bytes are echoed; a spec of '%',
// an optional '0' flag, width digits and d, x or X prints the value padded to
// the width. Byte 0 ends the string and is flagged with string_end_o.
// Result bytes leave on the output channel (out_valid_o / out_stall_i) through
// one output register; run_last_o marks the last byte of a request.
// The sequencer runs one control word per cycle unless it waits for an input
// byte or a stalled receiver, and takes one request at a time. A literal or
// NUL byte is fetched, decoded and echoed; a flag or width byte is fetched and
// decoded. A conversion renders up to 10 digits and any sign into the buffer,
// then emits a zero-filled sign, the padding and the digits; an unknown
// conversion of a nonzero value renders no digits and prints only padding.
// When the receiver stalls, the sequencer holds at its emit step and the
// output register keeps its byte. Reset returns to literal mode with no
// pending output; the digit buffer is not cleared.

module format_string_integer_printer #(
  parameter int WIDTH_LIMIT = fsip_pkg::WIDTH_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         fmt_char_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               run_last_o,
  output logic               string_end_o
);

  localparam int WW = $clog2(WIDTH_LIMIT + 1);
  localparam logic [WW+3:0] LIMIT_X = (WW + 4)'(WIDTH_LIMIT);
  localparam fsip_pkg::pos_t POS_END = fsip_pkg::pos_t'(fsip_pkg::BUF_DEPTH);

  fsip_pkg::uword_t uw;

  fsip_pkg::pc_t    pc_q, pc_d;
  fsip_pkg::phase_e phase_q, phase_d;
  logic             zf_q, zf_d;
  logic [WW-1:0]    width_q, width_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       ch_q, ch_d;
  logic [31:0]      val_q, val_d;
  logic [31:0]      mag_q, mag_d;
  logic             hex_q, hex_d;
  logic             upper_q, upper_d;
  logic             neg_q, neg_d;
  fsip_pkg::pos_t   pos_q, pos_d;
  logic [WW-1:0]    pad_q, pad_d;
  logic [WW-1:0]    rem_q, rem_d;
  logic [7:0]       dbuf_q [fsip_pkg::BUF_DEPTH];

  logic [7:0]       oc_q, oc_d;
  logic             ol_q, ol_d;
  logic             oe_q, oe_d;

  logic             accept, out_busy, hold, flag;
  fsip_pkg::pc_t    disp;
  logic             emit;
  logic [7:0]       emit_ch;
  logic             emit_last, emit_end;
  logic             wr_en;
  fsip_pkg::pos_t   wr_idx;
  logic [7:0]       wr_data;

  logic [63:0]      prod;
  logic [31:0]      quot, dec_rem, next_mag;
  logic [3:0]       nib;
  logic [7:0]       dig_ch;
  logic [WW+3:0]    wsum;
  logic [WW-1:0]    len_w, total_w, pad_w;
  logic             is_digit, unknown;

  assign uw = fsip_pkg::ucode(pc_q);
  assign in_stall_o = (uw.op != fsip_pkg::OP_FETCH);
  assign accept = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o = oc_q;
  assign run_last_o = ol_q;
  assign string_end_o = oe_q;

  // digit datapath
  assign prod = {32'd0, mag_q} * {32'd0, fsip_pkg::DIV10_MAGIC};
  assign quot = {3'd0, prod[63:35]};
  assign dec_rem = mag_q - ({quot[28:0], 3'd0} + {quot[30:0], 1'b0});
  assign nib = hex_q ? mag_q[3:0] : dec_rem[3:0];
  assign next_mag = hex_q ? {4'd0, mag_q[31:4]} : quot;
  assign dig_ch = (nib < 4'd10) ? (fsip_pkg::CH_0 + {4'd0, nib})
                : ((upper_q ? fsip_pkg::CH_UA : fsip_pkg::CH_LA) + {4'd0, nib} - 8'd10);

  assign is_digit = (ch_q >= fsip_pkg::CH_0) && (ch_q <= fsip_pkg::CH_9);
  assign unknown = (ch_q != fsip_pkg::CH_D) && (ch_q != fsip_pkg::CH_LX)
                && (ch_q != fsip_pkg::CH_UX);
  assign wsum = {1'b0, width_q, 3'd0} + {3'd0, width_q, 1'b0}
              + (WW + 4)'(ch_q - fsip_pkg::CH_0);
  assign len_w = WW'(POS_END - pos_q);
  assign pad_w = (width_q > len_w) ? (width_q - len_w) : '0;
  assign total_w = pad_w + len_w;

  always_comb begin
    pc_d = pc_q;
    phase_d = phase_q;
    zf_d = zf_q;
    width_d = width_q;
    ch_d = ch_q;
    val_d = val_q;
    mag_d = mag_q;
    hex_d = hex_q;
    upper_d = upper_q;
    neg_d = neg_q;
    pos_d = pos_q;
    pad_d = pad_q;
    rem_d = rem_q;
    hold = 1'b0;
    flag = 1'b0;
    disp = fsip_pkg::S_FETCH;
    emit = 1'b0;
    emit_ch = ch_q;
    emit_last = 1'b0;
    emit_end = 1'b0;
    wr_en = 1'b0;
    wr_idx = pos_q - 1'b1;
    wr_data = dig_ch;

    unique case (uw.op)
      fsip_pkg::OP_FETCH: begin
        hold = !in_valid_i;
        if (accept) begin
          ch_d = fmt_char_i;
          val_d = value_i;
        end
      end
      fsip_pkg::OP_DECODE: begin
        priority if (ch_q == fsip_pkg::CH_NUL) begin
          phase_d = fsip_pkg::PH_LITERAL;
          zf_d = 1'b0;
          width_d = '0;
          disp = fsip_pkg::S_EMIT_CH;
        end else if (phase_q == fsip_pkg::PH_LITERAL) begin
          if (ch_q == fsip_pkg::CH_PCT) begin
            phase_d = fsip_pkg::PH_PERCENT;
            zf_d = 1'b0;
            width_d = '0;
          end else begin
            disp = fsip_pkg::S_EMIT_CH;
          end
        end else if (phase_q == fsip_pkg::PH_PERCENT && ch_q == fsip_pkg::CH_0) begin
          zf_d = 1'b1;
          phase_d = fsip_pkg::PH_WIDTH;
        end else if (is_digit) begin
          width_d = (wsum > LIMIT_X) ? WW'(WIDTH_LIMIT) : wsum[WW-1:0];
          phase_d = fsip_pkg::PH_WIDTH;
        end else begin
          disp = fsip_pkg::S_REN_INIT;
        end
      end
      fsip_pkg::OP_EMIT_CH: begin
        emit = 1'b1;
        emit_ch = ch_q;
        emit_last = 1'b1;
        emit_end = (ch_q == fsip_pkg::CH_NUL);
        hold = out_busy;
      end
      fsip_pkg::OP_REN_INIT: begin
        pos_d = POS_END;
        hex_d = (ch_q != fsip_pkg::CH_D);
        upper_d = (ch_q == fsip_pkg::CH_UX);
        neg_d = (ch_q == fsip_pkg::CH_D) && val_q[31];
        mag_d = ((ch_q == fsip_pkg::CH_D) && val_q[31]) ? (32'd0 - val_q) : val_q;
        flag = unknown && (val_q != 32'd0);
      end
      fsip_pkg::OP_REN_DIG: begin
        wr_en = 1'b1;
        pos_d = pos_q - 1'b1;
        mag_d = next_mag;
        flag = (next_mag != 32'd0);
      end
      fsip_pkg::OP_REN_SIGN: begin
        if (neg_q) begin
          wr_en = 1'b1;
          wr_data = fsip_pkg::CH_MINUS;
          pos_d = pos_q - 1'b1;
        end
      end
      fsip_pkg::OP_PREP: begin
        pad_d = pad_w;
        rem_d = total_w;
        flag = (total_w == '0);
      end
      fsip_pkg::OP_EMIT_SIGN: begin
        if (zf_q && pos_q != POS_END && dbuf_q[pos_q] == fsip_pkg::CH_MINUS) begin
          emit = 1'b1;
          emit_ch = fsip_pkg::CH_MINUS;
          emit_last = (rem_q == WW'(1));
          hold = out_busy;
          if (!out_busy) begin
            pos_d = pos_q + 1'b1;
            rem_d = rem_q - 1'b1;
          end
        end
      end
      fsip_pkg::OP_EMIT_PAD: begin
        if (pad_q != '0) begin
          emit = 1'b1;
          emit_ch = zf_q ? fsip_pkg::CH_0 : fsip_pkg::CH_SPACE;
          emit_last = (rem_q == WW'(1));
          hold = out_busy;
          flag = (pad_q != WW'(1));
          if (!out_busy) begin
            pad_d = pad_q - 1'b1;
            rem_d = rem_q - 1'b1;
          end
        end
      end
      fsip_pkg::OP_EMIT_DIG: begin
        if (pos_q != POS_END) begin
          emit = 1'b1;
          emit_ch = dbuf_q[pos_q];
          emit_last = (rem_q == WW'(1));
          hold = out_busy;
          flag = ((pos_q + 1'b1) != POS_END);
          if (!out_busy) begin
            pos_d = pos_q + 1'b1;
            rem_d = rem_q - 1'b1;
          end
        end
      end
      fsip_pkg::OP_CLEAR: begin
        phase_d = fsip_pkg::PH_LITERAL;
        zf_d = 1'b0;
        width_d = '0;
      end
      default: begin
        hold = 1'b0;
      end
    endcase

    if (!hold) begin
      unique case (uw.cond)
        fsip_pkg::C_NEXT:     pc_d = pc_q + 1'b1;
        fsip_pkg::C_GOTO:     pc_d = uw.target;
        fsip_pkg::C_DISPATCH: pc_d = disp;
        fsip_pkg::C_IF:       pc_d = flag ? uw.target : (pc_q + 1'b1);
        default:              pc_d = fsip_pkg::S_FETCH;
      endcase
    end

    out_valid_d = out_valid_q;
    oc_d = oc_q;
    ol_d = ol_q;
    oe_d = oe_q;
    if (emit && !out_busy) begin
      out_valid_d = 1'b1;
      oc_d = emit_ch;
      ol_d = emit_last;
      oe_d = emit_end;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fsip_pkg::S_FETCH;
      phase_q <= fsip_pkg::PH_LITERAL;
      zf_q <= 1'b0;
      width_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      phase_q <= phase_d;
      zf_q <= zf_d;
      width_q <= width_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    val_q <= val_d;
    mag_q <= mag_d;
    hex_q <= hex_d;
    upper_q <= upper_d;
    neg_q <= neg_d;
    pos_q <= pos_d;
    pad_q <= pad_d;
    rem_q <= rem_d;
    oc_q <= oc_d;
    ol_q <= ol_d;
    oe_q <= oe_d;
    if (wr_en) begin
      dbuf_q[wr_idx] <= wr_data;
    end
  end

endmodule
